/* rtl/generational_handle_allocator_unit_macros.svh */
// assertion macros for the generational handle allocator
// used by modules that check their own logic, needs clk_i and rst_ni in scope
`ifndef GENERATIONAL_HANDLE_ALLOCATOR_UNIT_MACROS_SVH
`define GENERATIONAL_HANDLE_ALLOCATOR_UNIT_MACROS_SVH

// same-cycle implication
`define GHAU_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ghau assertion failed");

// next-cycle implication
`define GHAU_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ghau assertion failed");

`endif

/* rtl/ghau_pkg.sv */
// shared types and constants of the generational handle allocator
// no dependencies
package ghau_pkg;

  localparam int unsigned MAX_SLOTS = 4096;
  localparam int unsigned GEN_BITS  = 8;

  localparam int unsigned IDX_W = $clog2(MAX_SLOTS);
  localparam int unsigned CNT_W = $clog2(MAX_SLOTS + 1);
  localparam int unsigned GEN_W = GEN_BITS;
  localparam int unsigned THR_W = 13;
  localparam int unsigned CMP_W = (CNT_W > THR_W) ? CNT_W : THR_W;
  localparam int unsigned TBL_W = GEN_W + 1;

  localparam logic [THR_W-1:0] THR_RESET = THR_W'(1024);
  localparam logic [CNT_W-1:0] MAX_CNT   = CNT_W'(MAX_SLOTS);
  localparam logic [IDX_W-1:0] IDX_LAST  = IDX_W'(MAX_SLOTS - 1);

  typedef enum logic [1:0] {
    OP_CREATE = 2'd0,
    OP_REMOVE = 2'd1,
    OP_QUERY  = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_DEAD  = 2'd2,
    ST_NO_TF = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOK,
    S_BUMP,
    S_RESP
  } state_e;

  typedef struct packed {
    op_e              operation;
    logic [IDX_W-1:0] handle_index;
    logic [GEN_W-1:0] handle_generation;
    logic             has_transform;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0] result_index;
    logic [GEN_W-1:0] result_generation;
    logic             alive;
    status_e          status;
  } out_item_t;

  typedef struct packed {
    logic             live;
    logic [GEN_W-1:0] gen;
  } tbl_entry_t;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic look;
    logic bump;
    logic load_out;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic need_bump;
    logic out_free;
  } sts_t;

endpackage

/* rtl/generational_handle_allocator_unit.sv */
// top level of the generational handle allocator
// depends on ghau_pkg, ghau_ctrl, ghau_dp and ghau_ram
//
//   port group   direction  handshake              payload
//   in           into       in_valid_i/in_stall_o   in_item_i   (in_item_t)
//   out          out of     out_valid_o/out_stall_i out_item_o  (out_item_t)
//   cfg          into       cfg_we_i                cfg_wdata_i (reuse threshold)
//
// an item passes through the look and result states (remove, query, fresh create,
// error), and a create that reuses a freed slot also passes through the bump state;
// the reuse path adds a read of the queued slot's generation because the table and
// the fifo both return read data in the cycle after their address is given
// the next item is taken in the cycle the previous result moves into the
// output register, so a held result stalls the input only while
// out_stall_i keeps the output register full
// reset is asynchronous, active low; no clearing pass runs, the fill count
// of appended slots stands in for a cleared live-bit table
module generational_handle_allocator_unit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // request channel
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  ghau_pkg::in_item_t         in_item_i,
  // result channel
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output ghau_pkg::out_item_t        out_item_o,
  // reuse threshold register
  input  logic                       cfg_we_i,
  input  logic [ghau_pkg::THR_W-1:0] cfg_wdata_i
);
  import ghau_pkg::*;

  // command and status between sequencer and datapath
  cmd_t cmd;
  sts_t sts;

  // sequencer: idle, look up, generation bump on reuse, hand over result
  ghau_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // datapath: generation/live table, free fifo, counters, output register
  ghau_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_item_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule

/* rtl/ghau_ram.sv */
// generic simple dual port ram, one write and one registered read port
// no dependencies
module ghau_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/ghau_ctrl.sv */
// sequencing state machine of the handle allocator
// depends on ghau_pkg
module ghau_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  ghau_pkg::sts_t sts_i,
  output ghau_pkg::cmd_t cmd_o
);
  import ghau_pkg::*;

  state_e state_q, state_d;
  logic   take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d  = state_q;
    take     = 1'b0;
    cmd_o    = '0;
    unique case (state_q)
      S_IDLE: begin
        take = 1'b1;
        if (in_valid_i) begin
          state_d = S_LOOK;
        end
      end
      S_LOOK: begin
        cmd_o.look = 1'b1;
        state_d    = sts_i.need_bump ? S_BUMP : S_RESP;
      end
      S_BUMP: begin
        cmd_o.bump = 1'b1;
        state_d    = S_RESP;
      end
      S_RESP: begin
        // result leaves and the next item can come in the same cycle
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          take           = 1'b1;
          state_d        = in_valid_i ? S_LOOK : S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
    cmd_o.accept = take && in_valid_i;
  end

  assign in_stall_o = !take;

endmodule

/* rtl/ghau_dp.sv */
// datapath: generation table, free slot fifo, counters and output register
// depends on ghau_pkg, ghau_ram and the assertion macro header
`include "generational_handle_allocator_unit_macros.svh"

module ghau_dp (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  ghau_pkg::in_item_t         in_item_i,
  input  logic                       cfg_we_i,
  input  logic [ghau_pkg::THR_W-1:0] cfg_wdata_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output ghau_pkg::out_item_t        out_item_o,
  input  ghau_pkg::cmd_t             cmd_i,
  output ghau_pkg::sts_t             sts_o
);
  import ghau_pkg::*;

  in_item_t         req_q;
  out_item_t        res_q, res_d, out_q;
  logic             out_valid_q;
  logic [THR_W-1:0] thr_q;
  logic [CNT_W-1:0] used_q, count_q;
  logic [IDX_W-1:0] head_q, tail_q, idx_q;

  tbl_entry_t       tbl_rd, tbl_wdata;
  logic             tbl_we;
  logic [IDX_W-1:0] tbl_waddr, tbl_raddr;
  logic [IDX_W-1:0] q_rd;
  logic             q_we;

  logic is_create, is_remove, reuse, full, hit, fresh, push;
  logic [GEN_W-1:0] new_gen;

  ghau_ram #(.WIDTH(TBL_W), .DEPTH(MAX_SLOTS)) u_tbl (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (tbl_waddr),
    .wdata_i (tbl_wdata),
    .raddr_i (tbl_raddr),
    .rdata_o (tbl_rd)
  );

  ghau_ram #(.WIDTH(IDX_W), .DEPTH(MAX_SLOTS)) u_fifo (
    .clk_i   (clk_i),
    .we_i    (q_we),
    .waddr_i (tail_q),
    .wdata_i (req_q.handle_index),
    .raddr_i (head_q),
    .rdata_o (q_rd)
  );

  always_comb begin
    is_create = (req_q.operation == OP_CREATE);
    is_remove = (req_q.operation == OP_REMOVE);
    full      = (used_q == MAX_CNT);
    reuse     = (CMP_W'(count_q) > CMP_W'(thr_q)) || (full && (count_q != '0));
    // slots at or above the fill count were never written
    hit       = (CNT_W'(req_q.handle_index) < used_q)
             && (tbl_rd.gen == req_q.handle_generation) && tbl_rd.live;
    fresh     = is_create && req_q.has_transform && !reuse && !full;
    push      = cmd_i.look && is_remove && hit && (count_q < MAX_CNT);
    new_gen   = tbl_rd.gen + GEN_W'(1);

    // in the look cycle a reuse needs the queued slot's generation
    tbl_raddr = cmd_i.look ? q_rd : in_item_i.handle_index;
    q_we      = push;

    tbl_we    = 1'b0;
    tbl_waddr = req_q.handle_index;
    tbl_wdata = '{live: 1'b0, gen: tbl_rd.gen};
    if (cmd_i.bump) begin
      tbl_we    = 1'b1;
      tbl_waddr = idx_q;
      tbl_wdata = '{live: 1'b1, gen: new_gen};
    end else if (cmd_i.look && fresh) begin
      tbl_we    = 1'b1;
      tbl_waddr = used_q[IDX_W-1:0];
      tbl_wdata = '{live: 1'b1, gen: '0};
    end else if (cmd_i.look && is_remove && hit) begin
      tbl_we = 1'b1;
    end

    res_d = '{result_index: '0, result_generation: '0, alive: 1'b0, status: ST_OK};
    if (cmd_i.bump) begin
      res_d.result_index      = idx_q;
      res_d.result_generation = new_gen;
    end else begin
      unique case (req_q.operation)
        OP_CREATE: begin
          priority if (!req_q.has_transform) begin
            res_d.status = ST_NO_TF;
          end else if (reuse) begin
            res_d.status = ST_OK;
          end else if (full) begin
            res_d.status = ST_FULL;
          end else begin
            res_d.result_index = used_q[IDX_W-1:0];
          end
        end
        OP_REMOVE: begin
          if (!hit) begin
            res_d.status = ST_DEAD;
          end
        end
        default: begin
          // query, and the unused code behaves the same
          res_d.alive = hit;
          if (!hit) begin
            res_d.status = ST_DEAD;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      req_q <= in_item_i;
    end
    if (cmd_i.look) begin
      idx_q <= q_rd;
    end
    if (cmd_i.look || cmd_i.bump) begin
      res_q <= res_d;
    end
    if (cmd_i.load_out) begin
      out_q <= res_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q       <= THR_RESET;
      used_q      <= '0;
      count_q     <= '0;
      head_q      <= '0;
      tail_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        thr_q <= cfg_wdata_i;
      end
      if (cmd_i.look && fresh) begin
        used_q <= used_q + CNT_W'(1);
      end
      if (push) begin
        tail_q  <= (tail_q == IDX_LAST) ? '0 : tail_q + IDX_W'(1);
        count_q <= count_q + CNT_W'(1);
      end else if (cmd_i.bump) begin
        head_q  <= (head_q == IDX_LAST) ? '0 : head_q + IDX_W'(1);
        count_q <= count_q - CNT_W'(1);
      end
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign sts_o.need_bump = is_create && req_q.has_transform && reuse;
  assign sts_o.out_free  = !out_valid_q || !out_stall_i;
  assign out_valid_o     = out_valid_q;
  assign out_item_o      = out_q;

  // every queued slot is a distinct slot that was handed out before
  `GHAU_ASSERT_NOW(a_count_le_used, 1'b1, count_q <= used_q)
  // a pop only ever happens on a non-empty queue
  `GHAU_ASSERT_NOW(a_bump_nonempty, cmd_i.bump, count_q != '0)
  // empty queue means head and tail meet
  `GHAU_ASSERT_NOW(a_empty_ptrs, count_q == '0, head_q == tail_q)
  // a fresh append leaves the fill count one higher
  `GHAU_ASSERT_NEXT(a_fresh_grows, cmd_i.look && fresh, used_q == $past(used_q) + CNT_W'(1))

endmodule

/* tb/sv/testbench.sv */
// testbench for generational_handle_allocator_unit: a directed table, then random
// create, remove and query traffic, scored against an in-bench model of the slot table
// depends on ghau_pkg and the allocator rtl only
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import ghau_pkg::*;

  // unused operation code, answered like a query
  localparam op_e OP_SPARE = op_e'(2'd3);

  // cycles without any handshake before the run is declared hung; the slowest
  // correct item spans an idle input gap, the busy states and a stalled output
  localparam int unsigned STALL_LIMIT = 500;

  localparam in_item_t  NO_REQ  = '0;
  localparam out_item_t NO_WANT = '0;

  // one row of the directed table: a threshold write or an item, with a typed
  // result where it is obvious, otherwise the model's answer is used
  typedef struct packed {
    logic             is_cfg;
    logic [THR_W-1:0] cfg_value;
    logic             typed;
    in_item_t         item;
    out_item_t        want;
  } plan_row_t;

  localparam int NUM_PLAN_ROWS = 27;

  // ---------------------------------------------------------------------------
  // dut signals; every input is driven to a known value from time zero
  // ---------------------------------------------------------------------------
  logic             clk_i;
  logic             rst_ni      = 1'b0;
  logic             in_valid_i  = 1'b0;
  logic             in_stall_o;
  in_item_t         in_item_i   = '0;
  logic             out_valid_o;
  logic             out_stall_i = 1'b0;
  out_item_t        out_item_o;
  logic             cfg_we_i    = 1'b0;
  logic [THR_W-1:0] cfg_wdata_i = THR_RESET;

  generational_handle_allocator_unit DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // model of the allocator state
  // ---------------------------------------------------------------------------
  logic [GEN_W-1:0] slot_gen  [MAX_SLOTS];
  bit               slot_live [MAX_SLOTS];
  int unsigned      slots_in_use = 0;
  logic [IDX_W-1:0] freed_slots [$];     // oldest freed slot at the front
  logic [THR_W-1:0] reuse_limit = THR_RESET;

  // results still owed by the dut, oldest first
  out_item_t pending_replies [$];

  // item currently on the request channel: typed expectation, if any
  logic      cur_typed = 1'b0;
  out_item_t cur_want  = '0;

  int unsigned items_sent       = 0;
  int unsigned results_checked  = 0;
  int unsigned mismatch_count   = 0;
  int unsigned idle_cycles      = 0;
  int unsigned settings_written = 0;
  int unsigned reuse_count      = 0;
  int unsigned wrap_count       = 0;
  int unsigned full_count       = 0;

  // idle draw state of each side; a nonzero value means a run of items with no gaps
  int unsigned calm_in  = 0;
  int unsigned calm_out = 0;

  initial begin
    foreach (slot_gen[i]) slot_gen[i] = '0;
  end

  function automatic bit handle_is_live(logic [IDX_W-1:0] idx, logic [GEN_W-1:0] gen);
    if (idx >= slots_in_use) return 1'b0;
    return slot_gen[idx] == gen && slot_live[idx];
  endfunction

  // applies one request to the model and returns the result it must produce
  function automatic out_item_t allocator_reply(in_item_t req);
    out_item_t   r;
    int unsigned s;
    r = '0;
    r.status = ST_OK;
    if (req.operation == OP_CREATE) begin
      if (!req.has_transform) begin
        r.status = ST_NO_TF;
      end else if (freed_slots.size() > reuse_limit ||
                   (slots_in_use >= MAX_SLOTS && freed_slots.size() > 0)) begin
        // oldest freed slot comes back one generation on
        s = freed_slots[0];
        freed_slots.delete(0);
        slot_gen[s]  = slot_gen[s] + 1'b1;
        slot_live[s] = 1'b1;
        r.result_index      = IDX_W'(s);
        r.result_generation = slot_gen[s];
        reuse_count++;
        if (slot_gen[s] == '0) wrap_count++;
      end else if (slots_in_use >= MAX_SLOTS) begin
        r.status = ST_FULL;
        full_count++;
      end else begin
        s = slots_in_use;
        slot_gen[s]  = '0;
        slot_live[s] = 1'b1;
        slots_in_use++;
        r.result_index = IDX_W'(s);
      end
    end else if (req.operation == OP_REMOVE) begin
      if (!handle_is_live(req.handle_index, req.handle_generation)) begin
        r.status = ST_DEAD;
      end else begin
        slot_live[req.handle_index] = 1'b0;
        if (freed_slots.size() < MAX_SLOTS)
          freed_slots.insert(freed_slots.size(), req.handle_index);
      end
    end else begin
      // query and the spare code
      if (handle_is_live(req.handle_index, req.handle_generation)) r.alive = 1'b1;
      else r.status = ST_DEAD;
    end
    return r;
  endfunction

  // any live slot, searched from a random start, or -1 when none is live
  function automatic int pick_live();
    int unsigned start;
    int unsigned j;
    if (slots_in_use == 0) return -1;
    start = $urandom_range(0, slots_in_use - 1);
    for (int unsigned k = 0; k < slots_in_use; k++) begin
      j = (start + k) % slots_in_use;
      if (slot_live[j]) return int'(j);
    end
    return -1;
  endfunction

  // idle cycles before the next item on one side; now and then a run with none
  function automatic int unsigned draw_gap(inout int unsigned calm);
    if (calm != 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) begin
      calm = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 16);
  endfunction

  // ---------------------------------------------------------------------------
  // scoreboard: sampled at the rising edge, results checked before the new
  // request is modeled so both orders within one step give the same answer
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : scoreboard
    out_item_t want;
    logic      moved;
    if (rst_ni) begin
      moved = 1'b0;
      if (out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
        moved = 1'b1;
        results_checked++;
        if (pending_replies.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("result with no request outstanding: index %0d gen %0d alive %0b status %0d",
                     out_item_o.result_index, out_item_o.result_generation,
                     out_item_o.alive, out_item_o.status);
        end else begin
          want = pending_replies[0];
          pending_replies.delete(0);
          if (out_item_o.result_index      !== want.result_index      ||
              out_item_o.result_generation !== want.result_generation ||
              out_item_o.alive             !== want.alive             ||
              out_item_o.status            !== want.status) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display({"result %0d: index %0d (exp %0d) gen %0d (exp %0d) ",
                        "alive %0b (exp %0b) status %0d (exp %0d)"},
                       results_checked,
                       out_item_o.result_index, want.result_index,
                       out_item_o.result_generation, want.result_generation,
                       out_item_o.alive, want.alive, out_item_o.status, want.status);
          end
        end
      end
      if (in_valid_i === 1'b1 && in_stall_o === 1'b0) begin
        moved = 1'b1;
        want = allocator_reply(in_item_i);
        pending_replies.insert(pending_replies.size(), cur_typed ? cur_want : want);
        items_sent++;
      end
      // watchdog on handshakes
      idle_cycles = moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("no handshake for %0d cycles, %0d results owed", STALL_LIMIT,
                 pending_replies.size());
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result side: stall for a drawn number of cycles, then take one item
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int unsigned gap;
    wait (rst_ni);
    @(negedge clk_i);
    forever begin
      gap = draw_gap(calm_out);
      if (gap != 0) begin
        out_stall_i <= 1'b1;
        repeat (gap) @(negedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!(out_valid_o === 1'b1 && out_stall_i === 1'b0));
      @(negedge clk_i);
    end
  end

  // ---------------------------------------------------------------------------
  // request side; every task is entered and left at a falling edge
  // ---------------------------------------------------------------------------
  task automatic send_req(input in_item_t req, input logic typed, input out_item_t want);
    int unsigned gap;
    gap = draw_gap(calm_in);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    // valid stays high straight into the next item when there is no gap
    in_valid_i <= 1'b1;
    in_item_i  <= req;
    cur_typed  <= typed;
    cur_want   <= want;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    @(negedge clk_i);
  endtask

  task automatic send_op(input op_e op, input int unsigned idx, input logic [GEN_W-1:0] gen);
    in_item_t req;
    req.operation         = op;
    req.handle_index      = IDX_W'(idx);
    req.handle_generation = gen;
    req.has_transform     = 1'b1;
    send_req(req, 1'b0, NO_WANT);
  endtask

  task automatic send_create();
    send_op(OP_CREATE, $urandom_range(0, IDX_LAST), GEN_W'($urandom_range(0, 255)));
  endtask

  // threshold writes happen only with nothing in flight
  task automatic write_threshold(input logic [THR_W-1:0] value);
    in_valid_i <= 1'b0;
    while (pending_replies.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    reuse_limit = value;
    settings_written++;
  endtask

  // mostly well-formed traffic on handles the model knows, plus noise
  task automatic send_mixed();
    in_item_t    req;
    int          pick;
    int unsigned roll;
    roll = $urandom_range(0, 99);
    pick = pick_live();
    req.operation         = OP_CREATE;
    req.handle_index      = IDX_W'($urandom_range(0, IDX_LAST));
    req.handle_generation = GEN_W'($urandom_range(0, 255));
    req.has_transform     = 1'b1;
    if (roll < 40 || (roll < 80 && pick < 0)) begin
      // create with junk in the handle fields
    end else if (roll < 65) begin
      req.operation         = OP_REMOVE;
      req.handle_index      = IDX_W'(pick);
      req.handle_generation = slot_gen[pick];
    end else if (roll < 80) begin
      req.operation         = OP_QUERY;
      req.handle_index      = IDX_W'(pick);
      req.handle_generation = slot_gen[pick];
      // a stale generation now and then
      if ($urandom_range(0, 2) == 0) req.handle_generation = slot_gen[pick] + 1'b1;
    end else begin
      req.operation     = op_e'($urandom_range(0, 3));
      req.has_transform = 1'($urandom_range(0, 1));
      if ($urandom_range(0, 1) != 0) req.handle_index = IDX_W'($urandom_range(0, slots_in_use));
    end
    send_req(req, 1'b0, NO_WANT);
  endtask

  // directed table: empty table, extremes, every operation and every status but full
  plan_row_t plan [NUM_PLAN_ROWS] = '{
    // reset threshold, nothing allocated yet
    '{1'b0, THR_W'(0), 1'b1, '{OP_QUERY,  12'd0,    8'd0,   1'b0}, '{12'd0, 8'd0, 1'b0, ST_DEAD}},
    '{1'b0, THR_W'(0), 1'b1, '{OP_QUERY,  12'd4095, 8'd255, 1'b1}, '{12'd0, 8'd0, 1'b0, ST_DEAD}},
    '{1'b0, THR_W'(0), 1'b1, '{OP_REMOVE, 12'd0,    8'd0,   1'b0}, '{12'd0, 8'd0, 1'b0, ST_DEAD}},
    // missing transform changes nothing
    '{1'b0, THR_W'(0), 1'b1, '{OP_CREATE, 12'd4095, 8'd255, 1'b0}, '{12'd0, 8'd0, 1'b0, ST_NO_TF}},
    '{1'b0, THR_W'(0), 1'b1, '{OP_CREATE, 12'd0,    8'd0,   1'b1}, '{12'd0, 8'd0, 1'b0, ST_OK}},
    '{1'b0, THR_W'(0), 1'b1, '{OP_CREATE, 12'd0,    8'd0,   1'b1}, '{12'd1, 8'd0, 1'b0, ST_OK}},
    '{1'b0, THR_W'(0), 1'b1, '{OP_QUERY,  12'd0,    8'd0,   1'b0}, '{12'd0, 8'd0, 1'b1, ST_OK}},
    '{1'b0, THR_W'(0), 1'b1, '{OP_QUERY,  12'd0,    8'd255, 1'b0}, '{12'd0, 8'd0, 1'b0, ST_DEAD}},
    '{1'b0, THR_W'(0), 1'b1, '{OP_SPARE,  12'd1,    8'd0,   1'b1}, '{12'd0, 8'd0, 1'b1, ST_OK}},
    // wrong generation, then a good remove, then the same handle again
    '{1'b0, THR_W'(0), 1'b1, '{OP_REMOVE, 12'd1,    8'd1,   1'b0}, '{12'd0, 8'd0, 1'b0, ST_DEAD}},
    '{1'b0, THR_W'(0), 1'b1, '{OP_REMOVE, 12'd1,    8'd0,   1'b0}, '{12'd0, 8'd0, 1'b0, ST_OK}},
    '{1'b0, THR_W'(0), 1'b1, '{OP_REMOVE, 12'd1,    8'd0,   1'b0}, '{12'd0, 8'd0, 1'b0, ST_DEAD}},
    '{1'b0, THR_W'(0), 1'b1, '{OP_QUERY,  12'd1,    8'd0,   1'b0}, '{12'd0, 8'd0, 1'b0, ST_DEAD}},
    // one slot freed but under the reset threshold, so a fresh slot
    '{1'b0, THR_W'(0), 1'b1, '{OP_CREATE, 12'd4095, 8'd255, 1'b1}, '{12'd2, 8'd0, 1'b0, ST_OK}},
    // threshold zero: any freed slot comes back
    '{1'b1, THR_W'(0), 1'b0, NO_REQ, NO_WANT},
    '{1'b0, THR_W'(0), 1'b0, '{OP_CREATE, 12'd0,    8'd0,   1'b1}, NO_WANT},
    '{1'b0, THR_W'(0), 1'b0, '{OP_QUERY,  12'd1,    8'd1,   1'b0}, NO_WANT},
    '{1'b0, THR_W'(0), 1'b0, '{OP_REMOVE, 12'd0,    8'd0,   1'b1}, NO_WANT},
    '{1'b0, THR_W'(0), 1'b0, '{OP_REMOVE, 12'd2,    8'd0,   1'b0}, NO_WANT},
    '{1'b0, THR_W'(0), 1'b0, '{OP_CREATE, 12'd0,    8'd0,   1'b1}, NO_WANT},
    '{1'b0, THR_W'(0), 1'b0, '{OP_CREATE, 12'd0,    8'd0,   1'b1}, NO_WANT},
    '{1'b0, THR_W'(0), 1'b0, '{OP_CREATE, 12'd0,    8'd0,   1'b1}, NO_WANT},
    '{1'b0, THR_W'(0), 1'b0, '{OP_SPARE,  12'd3,    8'd0,   1'b0}, NO_WANT},
    '{1'b0, THR_W'(0), 1'b0, '{OP_REMOVE, 12'd1,    8'd0,   1'b0}, NO_WANT},
    // threshold of MAX_SLOTS: freed slots are never reused until the table fills
    '{1'b1, THR_W'(4096), 1'b0, NO_REQ, NO_WANT},
    '{1'b0, THR_W'(0), 1'b0, '{OP_REMOVE, 12'd3,    8'd0,   1'b0}, NO_WANT},
    '{1'b0, THR_W'(0), 1'b0, '{OP_CREATE, 12'd0,    8'd0,   1'b1}, NO_WANT}
  };

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int s;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (int i = 0; i < NUM_PLAN_ROWS; i++) begin
      if (plan[i].is_cfg) write_threshold(plan[i].cfg_value);
      else send_req(plan[i].item, plan[i].typed, plan[i].want);
    end

    // random traffic under a small threshold, the lowest and one of MAX_SLOTS
    write_threshold(THR_W'($urandom_range(1, 8)));
    repeat (100) send_mixed();
    write_threshold(THR_W'(0));
    repeat (100) send_mixed();
    write_threshold(THR_W'(4096));
    repeat (100) send_mixed();

    // same-slot churn: with the free fifo empty and threshold zero, removing
    // one slot and creating again keeps bumping that same slot
    write_threshold(THR_W'(0));
    while (freed_slots.size() != 0) send_create();
    if (pick_live() < 0) send_create();
    s = pick_live();
    repeat (30) begin
      send_op(OP_REMOVE, s, slot_gen[s]);
      send_create();
      if ($urandom_range(0, 3) == 0) send_op(OP_QUERY, s, slot_gen[s] - 1'b1);
    end

    // drain, then leave room for any stray result
    in_valid_i <= 1'b0;
    while (pending_replies.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);

    $display("%0d requests, %0d results checked, %0d threshold writes",
             items_sent, results_checked, settings_written);
    $display("%0d slot reuses, %0d generation wraps, %0d full-table replies, %0d slots used",
             reuse_count, wrap_count, full_count, slots_in_use);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d mismatching results", mismatch_count);
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
